### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions on the core clock
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants and types for the modular exponentiation core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int WIDTH_DEFAULT = 62;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

### rtl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// bit-serial modular multiplier: one multiplier bit per cycle by interleaved
// double-and-add, each sum brought below the modulus by one compare-subtract
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_modmul #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH-1:0]      i_a,
    input  logic [WIDTH-1:0]      i_b,
    input  logic [WIDTH-1:0]      i_m,
    output logic [WIDTH-1:0]      o_product,
    output mexp_pkg::t_mm_status  o_status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_dbl;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_m;

    logic [WIDTH:0]   sum_acc;
    logic [WIDTH:0]   sum_dbl;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_dbl;

    always_comb begin
        sum_acc = {1'b0, r_acc} + {1'b0, r_dbl};
        sum_dbl = {1'b0, r_dbl} + {1'b0, r_dbl};
        if (!r_b[0]) begin
            n_acc = r_acc;
        end else if (sum_acc >= {1'b0, r_m}) begin
            n_acc = WIDTH'(sum_acc - {1'b0, r_m});
        end else begin
            n_acc = sum_acc[WIDTH-1:0];
        end
        if (sum_dbl >= {1'b0, r_m}) begin
            n_dbl = WIDTH'(sum_dbl - {1'b0, r_m});
        end else begin
            n_dbl = sum_dbl[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_dbl <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_dbl <= n_dbl;
            r_b   <= r_b >> 1;
        end
    end

    assign o_product     = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

### rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base to the power of exponent, modulo a configured modulus, by right-to-left
// square-and-multiply on one shared bit-serial modular multiplier
// usage: load the modulus through i_cfg_wr_en / i_cfg_wr_data while idle
// (a zero write is ignored, reset value is 1). one input transaction carries
// i_base_value and i_exponent; one output transaction returns o_power_result.
// a zero exponent gives 1 directly. otherwise the base is first reduced below
// the modulus by one multiply, then each exponent bit up to the highest set one
// costs one square and, for a set bit, one multiply before it; the multiplier
// steps one multiplier bit per cycle.
// one transaction at a time.
// reset clears the sequencer and the output valid flag; a stalled receiver
// holds the result in the output register while the next transaction is taken in
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [WIDTH-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_power_result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_NEXT   = 6'b000100,
        S_MUL    = 6'b001000,
        S_SQR    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_result;
    logic             r_out_valid;

    logic             in_fire;
    logic             out_load;
    logic [WIDTH-1:0] one_mod;
    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_product;
    mexp_pkg::t_mm_status mm_status;

    assign o_in_ready     = (r_state == S_IDLE);
    assign in_fire        = i_in_valid && o_in_ready;
    assign out_load       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign one_mod        = (r_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

    // sequencer and multiplier operand selection
    always_comb begin
        n_state  = r_state;
        mm_start = 1'b0;
        mm_a     = r_base;
        mm_b     = r_base;
        unique case (r_state)
            S_IDLE: begin
                mm_a = one_mod;
                mm_b = i_base_value;
                if (in_fire) begin
                    if (i_exponent == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_status.done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mm_a     = r_acc;
                    mm_start = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    mm_start = 1'b1;
                    n_state  = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_status.done) begin
                    mm_start = 1'b1;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_status.done) begin
                    n_state = S_NEXT;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    mexp_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (r_modulus),
        .o_product (mm_product),
        .o_status  (mm_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en && (i_cfg_wr_data != '0)) begin
                r_modulus <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_exp <= i_exponent;
            r_acc <= (i_exponent == '0) ? WIDTH'(1) : one_mod;
        end
        if ((r_state == S_REDUCE) && mm_status.done) begin
            r_base <= mm_product;
        end
        if ((r_state == S_MUL) && mm_status.done) begin
            r_acc <= mm_product;
        end
        if ((r_state == S_SQR) && mm_status.done) begin
            r_base <= mm_product;
            r_exp  <= r_exp >> 1;
        end
        if (out_load) begin
            r_result <= r_acc;
        end
    end

    `ASSERT_CLK(a_modulus_nonzero, i_clk, i_rst_n, r_modulus != '0, "modulus register is zero")
    `ASSERT_CLK(a_ready_mul_idle, i_clk, i_rst_n, o_in_ready |-> !mm_status.busy,
        "ready while multiplier busy")
    `ASSERT_CLK(a_operands_reduced, i_clk, i_rst_n,
        (r_state == S_NEXT) |-> (r_acc < r_modulus && r_base < r_modulus),
        "operand not reduced")
    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (r_state == S_IDLE && !r_out_valid && r_modulus == WIDTH'(1)),
        "reset state wrong")

endmodule

### bench/tb_modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// self-checking bench for the modular exponentiation core: a scoreboard
// class predicts each power from the accepted operands and the current
// modulus, then compares it with every output transaction in order. a
// directed part covers the field extremes, a modulus of one, a zero write
// to the modulus and zero bases and exponents. random phases follow, with
// new moduli and sender idling and receiver stalls in several mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modular_exponentiation_core;

    localparam int W = mexp_pkg::WIDTH_DEFAULT;
    localparam logic [W-1:0] FIELD_MAX = {W{1'b1}};
    localparam int STALL_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 10;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [W-1:0] i_cfg_wr_data = '0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    logic [W-1:0] i_base_value = '0;
    logic [W-1:0] i_exponent = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    logic [W-1:0] o_power_result;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int modulus_settings = 0;
    int idle_count = 0;

    class power_scoreboard;
        logic [W-1:0] modulus;
        logic [W-1:0] expected_powers[$];
        int mismatch_count;
        int checked_count;

        function new();
            modulus = 1;
            mismatch_count = 0;
            checked_count = 0;
        endfunction

        function void set_modulus(logic [W-1:0] value);
            if (value != 0) modulus = value;
        endfunction

        function logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
            logic [2*W-1:0] prod;
            prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
            return W'(prod % {{W{1'b0}}, m});
        endfunction

        function logic [W-1:0] pow_mod(logic [W-1:0] base, logic [W-1:0] exponent);
            logic [W-1:0] sq;
            logic [W-1:0] acc;
            if (exponent == 0) return 1;
            sq = base % modulus;
            acc = 1 % modulus;
            for (int i = 0; i < W; i++) begin
                if (exponent[i]) acc = mul_mod(acc, sq, modulus);
                sq = mul_mod(sq, sq, modulus);
            end
            return acc;
        endfunction

        function void note_operands(logic [W-1:0] base, logic [W-1:0] exponent);
            expected_powers.push_back(pow_mod(base, exponent));
        endfunction

        function void check_power(logic [W-1:0] actual);
            logic [W-1:0] want;
            if (expected_powers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: power %h", actual);
                return;
            end
            want = expected_powers.pop_front();
            checked_count++;
            if (actual !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("power mismatch: expected %h, actual %h", want, actual);
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    power_scoreboard sb;

    modular_exponentiation_core #(.WIDTH(W)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_power_result (o_power_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_operands(i_base_value, i_exponent);
            if (o_out_valid && i_out_ready) sb.check_power(o_power_result);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    function automatic logic [W-1:0] rand_field();
        return W'({$urandom, $urandom});
    endfunction

    task automatic send_operands(logic [W-1:0] base, logic [W-1:0] exponent);
        @(negedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_base_value <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_modulus(logic [W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        sb.set_modulus(value);
        modulus_settings++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(4))
            0: return FIELD_MAX;
            1: return W'($urandom_range(255, 2));
            2: return rand_field() >> $urandom_range(W - 1, 8);
            3: return rand_field() | (W'(1) << (W - 1));
            default: return rand_field();
        endcase
    endfunction

    function automatic logic [W-1:0] pick_base();
        case ($urandom_range(9))
            0: return '0;
            1: return FIELD_MAX;
            2: return W'($urandom_range(20));
            default: return rand_field();
        endcase
    endfunction

    function automatic logic [W-1:0] pick_exponent();
        int len;
        logic [W-1:0] mask;
        len = $urandom_range(W, 1);
        mask = (W'(1) << len) - 1;
        case ($urandom_range(15))
            0: return '0;
            1: return FIELD_MAX;
            2, 3, 4: return rand_field();
            default: return (rand_field() & mask) | (W'(1) << (len - 1));
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus of one
        send_operands('0, '0);
        send_operands(5, 7);
        send_operands(FIELD_MAX, '0);
        send_operands(FIELD_MAX, FIELD_MAX);

        // zero write must leave the modulus at one
        write_modulus('0);
        send_operands(9, 3);

        write_modulus(FIELD_MAX);
        send_operands(FIELD_MAX, FIELD_MAX);
        send_operands(FIELD_MAX - 1, FIELD_MAX);
        send_operands('0, 1);
        send_operands('0, '0);
        send_operands(2, 61);
        send_operands(1, FIELD_MAX);
        send_operands(3, 2);
        send_operands(FIELD_MAX, 1);
        send_operands(FIELD_MAX, '0);

        write_modulus(2);
        send_operands(FIELD_MAX, FIELD_MAX);
        send_operands(4, 1);

        write_modulus(1000000007);
        send_operands(2, 1000000005);
        send_operands(123456789, '0);
        send_operands(rand_field(), rand_field());

        for (int phase = 0; phase < 8; phase++) begin
            write_modulus(phase == 5 ? '0 : pick_modulus());
            case (phase / 2)
                0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
                1: begin sender_idle_pct = 88; recv_stall_pct = 0; end
                2: begin sender_idle_pct = 0; recv_stall_pct = 88; end
                default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) send_operands(pick_base(), pick_exponent());
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("checked %0d power results under %0d modulus writes", sb.checked_count,
                 modulus_settings);
        $display("idling mixes: none, sender 88%%, receiver 88%%, both 36%%");
        if (sb.mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", sb.mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation_core.sv
bench/tb_modular_exponentiation_core.sv
